// File: rtl/dual_mailbox_register_device_defines.svh
// Assertion macros shared by the register device RTL.
`ifndef DUAL_MAILBOX_REGISTER_DEVICE_DEFINES_SVH
`define DUAL_MAILBOX_REGISTER_DEVICE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside of reset.
`define DMRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DMRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DMRD_ASSERT(lbl, prop, msg)
`define DMRD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/dmrd_pkg.sv
// Shared constants, offset maps and command lookup for the mailbox register device.
package dmrd_pkg;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 32;
    localparam int VER_W  = 2;

    localparam int BOX_A_WORDS_DEFAULT = 6;
    localparam int COMMAND_TABLE_SIZE  = 32;
    localparam int TABLE_ENTRIES       = 32;
    localparam int CMD_W               = $clog2(TABLE_ENTRIES);

    localparam logic [DATA_W-1:0] READY_FLAG      = 32'd1;
    localparam logic [DATA_W-1:0] STATUS_DONE     = 32'd1;
    localparam logic [DATA_W-1:0] BOX_B_RESET_ST  = 32'd1;
    localparam logic [DATA_W-1:0] A_SPECIAL_CMD   = 32'd8;
    localparam logic [DATA_W-1:0] A_SPECIAL_WORD  = 32'd3;
    localparam logic [DATA_W-1:0] PSTATE_COUNT    = 32'd1;
    localparam logic [DATA_W-1:0] MEM_FREQ_MHZ    = 32'd800;

    typedef struct packed {
        logic [ADDR_W-1:0] ready_ofs;
        logic [ADDR_W-1:0] a_cmd_ofs;
        logic [ADDR_W-1:0] a_status_ofs;
        logic [ADDR_W-1:0] a_data_ofs;
        logic [ADDR_W-1:0] b_cmd_ofs;
        logic [ADDR_W-1:0] b_data_ofs;
        logic [ADDR_W-1:0] b_status_ofs;
        logic              has_cmds;
        logic [CMD_W-1:0]  pstates_cmd;
        logic [CMD_W-1:0]  memfreq_cmd;
    } version_map_t;

    localparam version_map_t VERSION_MAPS [4] = '{
        '{12'h034, 12'h528, 12'h564, 12'h598, 12'h714, 12'h700, 12'h704,
          1'b0, 5'h00, 5'h00},
        '{12'h028, 12'h528, 12'h564, 12'h998, 12'h714, 12'h700, 12'h704,
          1'b1, 5'h08, 5'h0a},
        '{12'h024, 12'h530, 12'h57c, 12'h9c4, 12'h718, 12'h700, 12'h704,
          1'b1, 5'h07, 5'h08},
        '{12'h024, 12'h528, 12'h564, 12'h998, 12'h71c, 12'h700, 12'h704,
          1'b1, 5'h07, 5'h09}
    };

    typedef struct packed {
        logic ready_hit;
        logic a_cmd_hit;
        logic a_status_hit;
        logic a_data_hit;
        logic b_cmd_hit;
        logic b_status_hit;
        logic b_data_hit;
    } match_t;

    function automatic int idx_width(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Mailbox B answer for a command under the selected version.
    function automatic logic [DATA_W-1:0] box_b_answer(logic [VER_W-1:0] ver,
                                                       logic [DATA_W-1:0] cmd);
        version_map_t      m;
        logic              known;
        logic [DATA_W-1:0] res;
        m     = VERSION_MAPS[ver];
        known = (cmd < DATA_W'(TABLE_ENTRIES)) && (cmd < DATA_W'(COMMAND_TABLE_SIZE))
                && m.has_cmds;
        res   = '0;
        if (known && (cmd[CMD_W-1:0] == m.pstates_cmd))
            res = PSTATE_COUNT;
        else if (known && (cmd[CMD_W-1:0] == m.memfreq_cmd))
            res = MEM_FREQ_MHZ;
        return res;
    endfunction

endpackage

// File: rtl/dmrd_req_if.sv
// Bus access channel: one read or write word per handshake.
interface dmrd_req_if;
    import dmrd_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

// File: rtl/dmrd_rsp_if.sv
// Result channel: one read data word per handshake.
interface dmrd_rsp_if;
    import dmrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/dmrd_cfg_if.sv
// Configuration write channel carrying the version select word.
interface dmrd_cfg_if;
    import dmrd_pkg::*;

    logic             valid;
    logic             ready;
    logic [VER_W-1:0] version_select;

    modport source (output valid, output version_select, input ready);
    modport sink   (input valid, input version_select, output ready);
endinterface

// File: rtl/dmrd_decode.sv
// Address decoder: matches an offset against the selected version's register map.
module dmrd_decode #(
    parameter int BOX_A_WORDS = dmrd_pkg::BOX_A_WORDS_DEFAULT
) (
    input  logic [dmrd_pkg::VER_W-1:0]                     version,
    input  logic [dmrd_pkg::ADDR_W-1:0]                    address,
    output dmrd_pkg::match_t                               hit,
    output logic [dmrd_pkg::idx_width(BOX_A_WORDS)-1:0]    a_index
);
    import dmrd_pkg::*;

    localparam int IDX_W = idx_width(BOX_A_WORDS);
    localparam logic [ADDR_W-1:0] A_SPAN = ADDR_W'(BOX_A_WORDS * 4);

    version_map_t      m;
    logic [ADDR_W-1:0] a_offset;

    assign m        = VERSION_MAPS[version];
    assign a_offset = address - m.a_data_ofs;
    // low two address bits select a byte within the word: drop them
    assign a_index  = a_offset[IDX_W+1:2];

    always_comb
    begin
        hit.ready_hit    = (address == m.ready_ofs);
        hit.a_cmd_hit    = (address == m.a_cmd_ofs);
        hit.a_status_hit = (address == m.a_status_ofs);
        hit.a_data_hit   = (address >= m.a_data_ofs) && (a_offset < A_SPAN);
        hit.b_cmd_hit    = (address == m.b_cmd_ofs);
        hit.b_status_hit = (address == m.b_status_ofs);
        hit.b_data_hit   = (address == m.b_data_ofs);
    end
endmodule

// File: rtl/dual_mailbox_register_device.sv
// Top level: register-mapped controller with two command mailboxes.
//
// Usage:
//   req  carries one bus access word per handshake: action (0 read, 1 write),
//        a 12-bit byte offset and 32-bit write data.
//   rsp  returns one read_data word per access, in order; writes and
//        unmapped reads return zero.
//   cfg  writes version_select, which picks the offset map and the mailbox B
//        command table. Write it only while no access is in flight.
// Latency: the result word is valid the cycle after the access is taken.
// Throughput: one access per cycle while no result stalls; decode, mailbox update and read select
//   all settle in the single stage ahead of the result register.
// Stall: while a result waits and rsp.ready is low, req.ready drops and the
//   result holds; accesses resume as soon as the word is taken.
// Reset: version 0, mailbox A status and data words zero, mailbox B status
//   one and data word zero, no result pending.
`include "dual_mailbox_register_device_defines.svh"

module dual_mailbox_register_device #(
    parameter int BOX_A_WORDS = dmrd_pkg::BOX_A_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    dmrd_req_if.sink    req,
    dmrd_rsp_if.source  rsp,
    dmrd_cfg_if.sink    cfg
);
    import dmrd_pkg::*;

    localparam int IDX_W = idx_width(BOX_A_WORDS);

    logic [VER_W-1:0]  version_reg;
    logic [DATA_W-1:0] box_a_status_reg, box_a_status_next;
    logic [DATA_W-1:0] box_a_words_reg [BOX_A_WORDS];
    logic [DATA_W-1:0] box_a_words_next [BOX_A_WORDS];
    logic [DATA_W-1:0] box_b_status_reg, box_b_status_next;
    logic [DATA_W-1:0] box_b_word_reg, box_b_word_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0] rsp_data_reg, rsp_data_next;

    match_t            hit;
    logic [IDX_W-1:0]  a_index;
    logic              accept;
    logic              b_run;

    dmrd_decode #(
        .BOX_A_WORDS (BOX_A_WORDS)
    ) u_decode (
        .version (version_reg),
        .address (req.address),
        .hit     (hit),
        .a_index (a_index)
    );

    assign cfg.ready     = 1'b1;
    assign req.ready     = !rsp_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    always_comb
    begin
        box_a_status_next = box_a_status_reg;
        box_a_words_next  = box_a_words_reg;
        box_b_status_next = box_b_status_reg;
        box_b_word_next   = box_b_word_reg;
        rsp_data_next     = rsp_data_reg;
        b_run             = 1'b0;
        rsp_valid_next    = rsp.ready ? 1'b0 : rsp_valid_reg;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            if (!req.action)
            begin
                if (hit.ready_hit)
                    rsp_data_next = READY_FLAG;
                else if (hit.a_status_hit)
                    rsp_data_next = box_a_status_reg;
                else if (hit.a_data_hit)
                    rsp_data_next = box_a_words_reg[a_index];
                else if (hit.b_status_hit)
                    rsp_data_next = box_b_status_reg;
                else if (hit.b_data_hit)
                    rsp_data_next = box_b_word_reg;
            end
            else
            begin
                if (hit.a_cmd_hit)
                begin
                    for (int i = 0; i < BOX_A_WORDS; i++)
                        box_a_words_next[i] = '0;
                    if (req.write_data == A_SPECIAL_CMD)
                        box_a_words_next[0] = A_SPECIAL_WORD;
                    box_a_status_next = STATUS_DONE;
                end
                else if (hit.a_status_hit)
                    box_a_status_next = req.write_data;
                else if (hit.a_data_hit)
                    box_a_words_next[a_index] = req.write_data;
                else if (hit.b_cmd_hit)
                begin
                    b_run             = 1'b1;
                    box_b_word_next   = box_b_answer(version_reg, req.write_data);
                    box_b_status_next = STATUS_DONE;
                end
                else if (hit.b_status_hit)
                    box_b_status_next = req.write_data;
                else if (hit.b_data_hit)
                    box_b_word_next = req.write_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg      <= '0;
            box_a_status_reg <= '0;
            for (int i = 0; i < BOX_A_WORDS; i++)
                box_a_words_reg[i] <= '0;
            box_b_status_reg <= BOX_B_RESET_ST;
            box_b_word_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                version_reg <= cfg.version_select;
            box_a_status_reg <= box_a_status_next;
            box_a_words_reg  <= box_a_words_next;
            box_b_status_reg <= box_b_status_next;
            box_b_word_reg   <= box_b_word_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    `DMRD_ASSERT(a_stall_blocks_req, (rsp.valid && !rsp.ready) |-> !req.ready,
                 "req taken while result stalled")
    `DMRD_ASSERT(a_accept_gives_rsp, accept |=> rsp.valid,
                 "accepted access produced no result")
    `DMRD_ASSERT(a_write_reads_zero, (accept && req.action) |=> (rsp.read_data == '0),
                 "write returned nonzero data")
    `DMRD_ASSERT(a_b_run_status, b_run |=> (box_b_status_reg == STATUS_DONE),
                 "mailbox B status not set after command")
    `DMRD_ASSERT(a_ready_flag,
                 (accept && !req.action && hit.ready_hit) |=> (rsp.read_data == READY_FLAG),
                 "ready flag read wrong")
endmodule
